FILE: hdl/mlft_pkg.sv
// ============================================================================
// mlft_pkg
// Shared types and constants for the MAC learning forwarding table.
// ============================================================================
package mlft_pkg;

  // Field widths fixed by the item format
  localparam int MacW      = 48;
  localparam int PortW     = 3;
  localparam int PortMaskW = 8;

  // Switch port count; mask bits at or above it are ignored
  localparam int NumPorts = 8;
  localparam logic [PortMaskW-1:0] PortValid =
    PortMaskW'((64'd1 << NumPorts) - 64'd1);

  // Configuration port
  localparam int PAddrW = 3;
  localparam int PDataW = 32;

  typedef enum logic [0:0] {
    RegAttached = 1'b0,
    RegBlocked  = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    OpLearn   = 1'b0,
    OpForward = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StFinish
  } srch_state_e;

  typedef struct packed {
    op_e              op;
    logic [MacW-1:0]  mac_addr;
    logic [PortW-1:0] port_index;
  } in_beat_t;

  typedef struct packed {
    logic [PortMaskW-1:0] send_mask;
    logic                 hit;
    logic                 learned;
    logic                 table_full;
  } out_beat_t;

  typedef struct packed {
    logic [PortMaskW-1:0] attached_ports;
    logic [PortMaskW-1:0] blocked_ports;
  } cfg_t;

  typedef struct packed {
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
  } entry_t;

  // One when the port is attached and lies below the port count
  function automatic logic port_att(cfg_t cfg, logic [PortW-1:0] p);
    logic [PortMaskW-1:0] m;
    m = cfg.attached_ports & PortValid;
    return m[p];
  endfunction

endpackage

FILE: hdl/mlft_csr.sv
// ============================================================================
// mlft_csr
// Configuration registers behind an APB-style port: attached and blocked masks.
// ============================================================================
module mlft_csr import mlft_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegAttached: cfg_d.attached_ports = pwdata[PortMaskW-1:0];
        RegBlocked:  cfg_d.blocked_ports  = pwdata[PortMaskW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_idx)
      RegAttached: prdata = {{(PDataW-PortMaskW){1'b0}}, cfg_q.attached_ports};
      RegBlocked:  prdata = {{(PDataW-PortMaskW){1'b0}}, cfg_q.blocked_ports};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hdl/mlft_tbl.sv
// ============================================================================
// mlft_tbl
// Entry store: one write port, one read port, read data registered.
// ============================================================================
module mlft_tbl import mlft_pkg::*; #(
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  assign rdata_o = rdata_q;

  // Store a new entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Fetch one entry per cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

FILE: hdl/mlft_srch.sv
// ============================================================================
// mlft_srch
// Search sequencer: walks the stored entries in insertion order, decides the
// result, appends learned entries and holds the result beat.
// ============================================================================
module mlft_srch import mlft_pkg::*; #(
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth),
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_beat_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_beat_t        out_data_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  entry_t           mem_rdata_i,
  output logic [CntW-1:0]  count_o
);

  srch_state_e      state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic             hit_q, hit_d;
  logic [PortW-1:0] hit_port_q, hit_port_d;
  in_beat_t         item_q, item_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  out_beat_t        res;
  logic             res_wr;
  logic             full;

  assign full        = (cnt_q == CntW'(Depth));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign count_o     = cnt_q;
  assign mem_raddr_o = idx_q[AddrW-1:0];
  assign mem_waddr_o = cnt_q[AddrW-1:0];
  assign mem_wdata_o = '{mac: item_q.mac_addr, port: item_q.port_index};

  // Decide the result from the search outcome
  always_comb begin
    res    = '0;
    res_wr = 1'b0;
    if (item_q.op == OpLearn) begin
      if (hit_q) begin
        res.hit = 1'b1;
      end else if (full) begin
        res.table_full = 1'b1;
      end else if (port_att(cfg_i, item_q.port_index)) begin
        res.learned = 1'b1;
        res_wr      = 1'b1;
      end
    end else if (port_att(cfg_i, item_q.port_index)) begin
      if (hit_q) begin
        res.hit = 1'b1;
        if (hit_port_q != item_q.port_index && port_att(cfg_i, hit_port_q)) begin
          res.send_mask = PortMaskW'(1) << hit_port_q;
        end
      end else begin
        res.send_mask = cfg_i.attached_ports & ~cfg_i.blocked_ports & PortValid
                        & ~(PortMaskW'(1) << item_q.port_index);
      end
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    hit_port_d  = hit_port_q;
    item_d      = item_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mem_re_o    = 1'b0;
    mem_we_o    = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          idx_d  = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          if (in_data_i.op == OpForward && !port_att(cfg_i, in_data_i.port_index)) begin
            state_d = StFinish;
          end else begin
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (pend_q && mem_rdata_i.mac == item_q.mac_addr) begin
          hit_d      = 1'b1;
          hit_port_d = mem_rdata_i.port;
          pend_d     = 1'b0;
          state_d    = StFinish;
        end else if (idx_q < cnt_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          idx_d    = idx_q + CntW'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = StFinish;
        end
      end
      StFinish: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res;
          out_valid_d = 1'b1;
          if (res_wr) begin
            mem_we_o = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hit_port_q <= hit_port_d;
    item_q     <= item_d;
    out_q      <= out_d;
  end

endmodule

FILE: hdl/mac_learning_forward_table_core.sv
// ============================================================================
// mac_learning_forward_table_core
// Switch forwarding table with address learning, lookup and flooding.
// ============================================================================
//
//  channel   direction  handshake            payload
//  in        sink       in_valid_i/in_ready_o   in_data_i  (in_beat_t)
//  out       source     out_valid_o/out_ready_i out_data_o (out_beat_t)
//  cfg       sink       psel/penable/pwrite     paddr, pwdata, prdata
//
//  The search reads one stored entry per cycle from the table, never more
//  than the entry count, and stops at the first match. A forward beat from
//  an unattached port skips the search. Reset clears the entry count and
//  both masks; the table itself needs no clearing. A stalled result beat
//  holds the sequencer in its final step.
//
module mac_learning_forward_table_core import mlft_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);

  cfg_t             cfg;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  entry_t           mem_rdata;
  logic [CntW-1:0]  count;

  // Configuration registers
  mlft_csr u_csr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Entry store
  mlft_tbl #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Search sequencer
  mlft_srch #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_srch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .count_o     (count)
  );

`ifndef SYNTHESIS
  // Fill level never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // Fill level only grows, by one entry at a time
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count != $past(count) |-> count == $past(count) + CntW'(1))
    else $error("entry count changed by other than one");

  // A table write is always reported as a learned beat
  a_write_learned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> out_valid_o && out_data_o.learned && !out_data_o.hit)
    else $error("table write without learned result");

  // One item at a time: no new beat right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");
`endif

endmodule
